// ----- sv/k_combination_enumerator_macros.svh -----
// Assertion macros for the k-combination enumerator.
`ifndef K_COMBINATION_ENUMERATOR_MACROS_SVH
`define K_COMBINATION_ENUMERATOR_MACROS_SVH

`ifndef SYNTHESIS

`define KCE_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kce assertion failed (same cycle)");

`define KCE_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kce assertion failed (next cycle)");

`else

`define KCE_ASSERT_IMP(label, clk, rst, ante, cons)
`define KCE_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- sv/kce_pkg.sv -----
// Constants and types shared by the k-combination enumerator.
package kce_pkg;

  localparam int MAX_SUBSET_DEF = 8;
  localparam int INDEX_BITS_DEF = 6;

  localparam int SET_SIZE_W    = 7;
  localparam int SUBSET_SIZE_W = 4;
  localparam int ELEM_W        = 6;
  localparam int NUM_ELEMS     = 8;
  localparam int CFG_IDX_W     = 1;

  localparam logic [SET_SIZE_W-1:0]    SET_SIZE_RST    = 7'd4;
  localparam logic [SUBSET_SIZE_W-1:0] SUBSET_SIZE_RST = 4'd2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_SET_SIZE    = 1'b0;
  localparam cfg_idx_t CFG_SUBSET_SIZE = 1'b1;

  typedef logic [ELEM_W-1:0] elem_t;

endpackage

// ----- sv/k_combination_enumerator.sv -----
// Lexicographic k-combination enumerator: top level.
//
// Usage:
//   Configuration: cfg_we/cfg_index/cfg_data write set_size (index 0) and
//   subset_size (index 1); write only while no request is outstanding.
//   Request channel: cmd_valid/cmd_stall with payload restart. restart=1
//   emits {0..k-1}; restart=0 emits the next combination in order.
//   Result channel: res_valid/res_stall with element_0..element_7,
//   last_combination and exhausted. Positions at or above k read zero;
//   exhausted results carry all-zero elements.
//   Result: registered, valid in the cycle after its request is accepted.
//   Throughput: one request per cycle while cmd_stall is low; the search for
//   the rightmost incrementable position and the refill sit in a single
//   combinational stage between the state registers and the result register.
//   cmd_stall is high only while a held result is stalled by the receiver;
//   the result and the enumeration state then hold.
//   Reset: set_size=4, subset_size=2, stored indexes ascending, not
//   started, so the first advance behaves like a restart.
`include "k_combination_enumerator_macros.svh"

module k_combination_enumerator #(
  parameter int MAX_SUBSET = kce_pkg::MAX_SUBSET_DEF,
  parameter int INDEX_BITS = kce_pkg::INDEX_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  kce_pkg::cfg_idx_t                 cfg_index,
  input  logic [kce_pkg::SET_SIZE_W-1:0]    cfg_data,
  input  logic                              cmd_valid,
  output logic                              cmd_stall,
  input  logic                              restart,
  output logic                              res_valid,
  input  logic                              res_stall,
  output kce_pkg::elem_t                    element_0,
  output kce_pkg::elem_t                    element_1,
  output kce_pkg::elem_t                    element_2,
  output kce_pkg::elem_t                    element_3,
  output kce_pkg::elem_t                    element_4,
  output kce_pkg::elem_t                    element_5,
  output kce_pkg::elem_t                    element_6,
  output kce_pkg::elem_t                    element_7,
  output logic                              last_combination,
  output logic                              exhausted
);

  // Width for n, k and the per-position limits n-k+i.
  localparam int NW = ((INDEX_BITS + 1) > kce_pkg::SET_SIZE_W) ?
                      (INDEX_BITS + 2) : (kce_pkg::SET_SIZE_W + 1);
  localparam int PW = (MAX_SUBSET > 1) ? $clog2(MAX_SUBSET) : 1;
  localparam int XE = (MAX_SUBSET > kce_pkg::NUM_ELEMS) ? MAX_SUBSET : kce_pkg::NUM_ELEMS;

  typedef logic [INDEX_BITS-1:0] idx_t;
  typedef logic [NW-1:0]         num_t;

  logic [kce_pkg::SET_SIZE_W-1:0]    set_size;
  logic [kce_pkg::SUBSET_SIZE_W-1:0] subset_size;

  idx_t cur [MAX_SUBSET];
  idx_t cur_next [MAX_SUBSET];
  logic started, started_next;
  logic finished, finished_next;

  kce_pkg::elem_t elem [kce_pkg::NUM_ELEMS];
  kce_pkg::elem_t elem_next [kce_pkg::NUM_ELEMS];
  logic last_next, exh_next;

  logic accept;
  num_t n_eff, k_eff;
  num_t lim [MAX_SUBSET];
  logic k_ok, found, is_last;
  logic [PW-1:0] pos;
  idx_t base;
  idx_t adv [MAX_SUBSET];
  idx_t cur_x [XE];

  assign cmd_stall = res_valid & res_stall;
  assign accept    = cmd_valid & ~cmd_stall;

  // Clamp n to the index range; check k against n and the lane count.
  always_comb begin
    k_eff = NW'(subset_size);
    if (NW'(set_size) > NW'(1 << INDEX_BITS)) begin
      n_eff = NW'(1 << INDEX_BITS);
    end else begin
      n_eff = NW'(set_size);
    end
    k_ok = (k_eff <= NW'(MAX_SUBSET)) && (k_eff <= n_eff);
    for (int i = 0; i < MAX_SUBSET; i++) begin
      lim[i] = n_eff - k_eff + NW'(i);
    end
  end

  // Rightmost position below its limit; the last hit in ascending order wins.
  always_comb begin
    found = 1'b0;
    pos   = '0;
    base  = '0;
    for (int i = 0; i < MAX_SUBSET; i++) begin
      if ((NW'(i) < k_eff) && (NW'(cur[i]) < lim[i])) begin
        found = 1'b1;
        pos   = PW'(i);
        base  = cur[i];
      end
    end
    for (int i = 0; i < MAX_SUBSET; i++) begin
      if (found && (PW'(i) >= pos) && (NW'(i) < k_eff)) begin
        adv[i] = INDEX_BITS'(int'(base) + 1 + i - int'(pos));
      end else begin
        adv[i] = cur[i];
      end
    end
  end

  always_comb begin
    started_next  = started;
    finished_next = finished;
    exh_next      = 1'b0;
    for (int i = 0; i < MAX_SUBSET; i++) begin
      cur_next[i] = cur[i];
    end
    priority if (!k_ok) begin
      started_next  = 1'b1;
      finished_next = 1'b1;
      exh_next      = 1'b1;
    end else if (restart || !started) begin
      started_next = 1'b1;
      for (int i = 0; i < MAX_SUBSET; i++) begin
        if (NW'(i) < k_eff) begin
          cur_next[i] = INDEX_BITS'(i);
        end
      end
    end else if (finished) begin
      exh_next = 1'b1;
    end else if (!found) begin
      finished_next = 1'b1;
      exh_next      = 1'b1;
    end else begin
      for (int i = 0; i < MAX_SUBSET; i++) begin
        cur_next[i] = adv[i];
      end
    end

    is_last = 1'b1;
    for (int i = 0; i < MAX_SUBSET; i++) begin
      if ((NW'(i) < k_eff) && (NW'(cur_next[i]) < lim[i])) begin
        is_last = 1'b0;
      end
    end
    if (!exh_next) begin
      finished_next = is_last;
    end
    last_next = is_last & ~exh_next;

    for (int i = 0; i < XE; i++) begin
      cur_x[i] = '0;
    end
    for (int i = 0; i < MAX_SUBSET; i++) begin
      cur_x[i] = cur_next[i];
    end
    for (int j = 0; j < kce_pkg::NUM_ELEMS; j++) begin
      if (!exh_next && (j < MAX_SUBSET) && (NW'(j) < k_eff)) begin
        elem_next[j] = kce_pkg::ELEM_W'(cur_x[j]);
      end else begin
        elem_next[j] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      set_size    <= kce_pkg::SET_SIZE_RST;
      subset_size <= kce_pkg::SUBSET_SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kce_pkg::CFG_SET_SIZE:    set_size    <= cfg_data;
        kce_pkg::CFG_SUBSET_SIZE: subset_size <= kce_pkg::SUBSET_SIZE_W'(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_SUBSET; i++) begin
        cur[i] <= INDEX_BITS'(i);
      end
      started   <= 1'b0;
      finished  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (accept) begin
        for (int i = 0; i < MAX_SUBSET; i++) begin
          cur[i] <= cur_next[i];
        end
        started  <= started_next;
        finished <= finished_next;
      end
      if (accept) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Result payload; no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int j = 0; j < kce_pkg::NUM_ELEMS; j++) begin
        elem[j] <= elem_next[j];
      end
      last_combination <= last_next;
      exhausted        <= exh_next;
    end
  end

  assign element_0 = elem[0];
  assign element_1 = elem[1];
  assign element_2 = elem[2];
  assign element_3 = elem[3];
  assign element_4 = elem[4];
  assign element_5 = elem[5];
  assign element_6 = elem[6];
  assign element_7 = elem[7];

  `KCE_ASSERT_NXT(a_accept_started, clk, rst, accept, started && res_valid)
  `KCE_ASSERT_IMP(a_exh_clean, clk, rst, res_valid && exhausted,
                  !last_combination && (element_0 == '0) && (element_1 == '0))
  `KCE_ASSERT_IMP(a_last_finished, clk, rst, res_valid && last_combination, finished)
  `KCE_ASSERT_NXT(a_after_end, clk, rst,
                  accept && started && finished && !restart, exhausted && finished)
  `KCE_ASSERT_NXT(a_exh_sets_done, clk, rst, accept && exh_next, finished)

endmodule
